>>> sv/sau_pkg.sv
// Shared types and constants for the strided arrangement unranker.
// Used by every module of the block except sau_ram; depends on nothing.
package sau_pkg;

   localparam int MAX_ELEMENTS  = 16;
   localparam int INDEX_BITS    = 48;
   localparam int ELEM_W        = $clog2(MAX_ELEMENTS);
   localparam int RAD_W         = ELEM_W + 1;
   localparam int NCNT_W        = ELEM_W + 1;
   localparam int CFG_N_W       = 5;
   localparam int CSR_INDEX_W   = 2;
   localparam int NARROW_BITS   = 8;
   localparam int NARROW_CYCLES = (INDEX_BITS + NARROW_BITS - 1) / NARROW_BITS;
   localparam int DIV_W         = NARROW_CYCLES * NARROW_BITS;
   localparam int DIV_CNT_W     = $clog2(DIV_W + 1);
   localparam int STACK_CNT_W   = $clog2(MAX_ELEMENTS + 1);

   localparam logic [CSR_INDEX_W-1:0] CSR_TOTAL  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FIXED  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_START  = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_STRIDE = 2'd3;

   localparam logic OP_NEXT   = 1'b0;
   localparam logic OP_UNRANK = 1'b1;

   localparam logic [CFG_N_W-1:0]    RESET_TOTAL  = 5'd16;
   localparam logic [INDEX_BITS-1:0] RESET_STRIDE = INDEX_BITS'(1);

   typedef enum logic [4:0] {
      S_SETUP,
      S_GROUP,
      S_LOAD_GO,
      S_LOAD_WAIT,
      S_IDLE,
      S_EXH,
      S_MOD_GO,
      S_MOD_WAIT,
      S_STEP,
      S_DSTART,
      S_DIG_GO,
      S_DIG_WAIT,
      S_SW_CHK,
      S_SW_WQ,
      S_SW_WO,
      S_EM_RD,
      S_EM_WR
   } state_type;

   typedef struct packed {
      logic                  start;
      logic                  narrow;
      logic [INDEX_BITS-1:0] dividend;
      logic [INDEX_BITS-1:0] divisor;
   } div_cmd_type;

   typedef struct packed {
      logic                  busy;
      logic                  done;
      logic [INDEX_BITS-1:0] quotient;
      logic [INDEX_BITS-1:0] remainder;
   } div_rsp_type;

   typedef struct packed {
      logic              push;
      logic              pop;
      logic [ELEM_W-1:0] din;
   } stack_ctl_type;

endpackage

>>> sv/strided_arrangement_unranker.sv
// Strided arrangement unranker: sequencer, walk state and result register.
// Depends on sau_pkg, sau_divider, sau_digits and sau_ram.
// Item: the modulo by the group size (one bit a cycle), then one narrow division
// per digit for N-M digits, a swap per nonzero digit and one RAM read per
// result word. One item at a time; an exhausted op 0 gives one exhausted word.
// Reset or a write of N, M or start stalls requests while the walk is rebuilt.
module strided_arrangement_unranker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_op,
   input  logic [sau_pkg::INDEX_BITS-1:0]       req_rank_in,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [sau_pkg::ELEM_W-1:0]           rsp_position,
   output logic [sau_pkg::ELEM_W-1:0]           rsp_element,
   output logic [sau_pkg::INDEX_BITS-1:0]       rsp_rank_used,
   output logic                                 rsp_last,
   output logic                                 rsp_exhausted,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [sau_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [sau_pkg::INDEX_BITS-1:0]       csr_wdata
);

   localparam int IB  = sau_pkg::INDEX_BITS;
   localparam int EW  = sau_pkg::ELEM_W;
   localparam int NW  = sau_pkg::NCNT_W;
   localparam int CW  = sau_pkg::CFG_N_W;
   localparam int RW  = sau_pkg::RAD_W;
   localparam int MAX = sau_pkg::MAX_ELEMENTS;

   sau_pkg::state_type state_ff, state_in;

   logic [CW-1:0] total_ff, total_in;
   logic [CW-1:0] fixed_ff, fixed_in;
   logic [IB-1:0] start_ff, start_in;
   logic [IB-1:0] stride_ff, stride_in;
   logic [IB-1:0] g_ff, g_in;
   logic [IB-1:0] walk_ff, walk_in;
   logic [IB-1:0] steps_ff, steps_in;
   logic [IB-1:0] used_ff, used_in;
   logic [IB-1:0] r_ff, r_in;
   logic [IB:0]   sum_ff, sum_in;
   logic [NW-1:0] gp_ff, gp_in;
   logic [NW-1:0] init_ff, init_in;
   logic [EW-1:0] p_ff, p_in;
   logic [EW-1:0] q_ff, q_in;
   logic [EW-1:0] o_ff, o_in;
   logic [EW-1:0] em_ff, em_in;
   logic [EW-1:0] tmp_ff, tmp_in;
   logic          op_ff, op_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [EW-1:0] rsp_position_ff, rsp_position_in;
   logic [EW-1:0] rsp_element_ff, rsp_element_in;
   logic [IB-1:0] rsp_rank_used_ff, rsp_rank_used_in;
   logic          rsp_last_ff, rsp_last_in;
   logic          rsp_exhausted_ff, rsp_exhausted_in;

   logic [NW-1:0]    n_eff;
   logic [EW-1:0]    n_last;
   logic             m_lt_n;
   logic             out_free;
   logic             csr_fire;
   logic             req_fire;
   logic [IB+NW-1:0] g_prod;
   logic [IB-1:0]    step_rank;

   sau_pkg::div_cmd_type   div_cmd;
   sau_pkg::div_rsp_type   div_rsp;
   sau_pkg::stack_ctl_type stk_ctl;
   logic [EW-1:0]          stk_top;
   logic                   stk_empty;

   logic          ram_wr_en;
   logic [EW-1:0] ram_wr_addr;
   logic [EW-1:0] ram_wr_data;
   logic [EW-1:0] ram_rd_addr_a;
   logic [EW-1:0] ram_rd_addr_b;
   logic [EW-1:0] ram_rd_data_a;
   logic [EW-1:0] ram_rd_data_b;

   sau_divider u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .rsp   (div_rsp)
   );

   sau_digits u_digits (
      .clock (clock),
      .reset (reset),
      .ctl   (stk_ctl),
      .top   (stk_top),
      .empty (stk_empty)
   );

   sau_ram #(
      .WIDTH (EW),
      .DEPTH (MAX)
   ) u_arr (
      .clock     (clock),
      .wr_en     (ram_wr_en),
      .wr_addr   (ram_wr_addr),
      .wr_data   (ram_wr_data),
      .rd_addr_a (ram_rd_addr_a),
      .rd_addr_b (ram_rd_addr_b),
      .rd_data_a (ram_rd_data_a),
      .rd_data_b (ram_rd_data_b)
   );

   assign csr_ready = (state_ff == sau_pkg::S_IDLE);
   assign req_stall = (state_ff != sau_pkg::S_IDLE) || csr_valid;
   assign csr_fire  = csr_valid && csr_ready;
   assign req_fire  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      if (total_ff == '0) begin
         n_eff = NW'(1);
      end else if (total_ff > CW'(MAX)) begin
         n_eff = NW'(MAX);
      end else begin
         n_eff = NW'(total_ff);
      end
   end

   assign n_last    = EW'(n_eff - 1'b1);
   assign m_lt_n    = fixed_ff < CW'(n_eff);
   assign g_prod    = (IB+NW)'(g_ff) * (IB+NW)'(gp_ff);
   assign step_rank = (sum_ff >= {1'b0, g_ff}) ? IB'(sum_ff - {1'b0, g_ff}) : sum_ff[IB-1:0];

   always_comb begin
      state_in  = state_ff;
      total_in  = total_ff;
      fixed_in  = fixed_ff;
      start_in  = start_ff;
      stride_in = stride_ff;
      g_in      = g_ff;
      walk_in   = walk_ff;
      steps_in  = steps_ff;
      used_in   = used_ff;
      r_in      = r_ff;
      sum_in    = sum_ff;
      gp_in     = gp_ff;
      init_in   = init_ff;
      p_in      = p_ff;
      q_in      = q_ff;
      o_in      = o_ff;
      em_in     = em_ff;
      tmp_in    = tmp_ff;
      op_in     = op_ff;

      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_position_in  = rsp_position_ff;
      rsp_element_in   = rsp_element_ff;
      rsp_rank_used_in = rsp_rank_used_ff;
      rsp_last_in      = rsp_last_ff;
      rsp_exhausted_in = rsp_exhausted_ff;

      div_cmd       = '0;
      stk_ctl       = '0;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = q_ff;
      ram_wr_data   = tmp_ff;
      ram_rd_addr_a = q_ff;
      ram_rd_addr_b = o_ff;

      case (state_ff)
         sau_pkg::S_SETUP: begin
            g_in     = IB'(1);
            gp_in    = n_eff;
            state_in = sau_pkg::S_GROUP;
         end
         sau_pkg::S_GROUP: begin
            if (CW'(gp_ff) > fixed_ff && gp_ff != '0) begin
               g_in  = g_prod[IB-1:0];
               gp_in = gp_ff - 1'b1;
            end else begin
               state_in = sau_pkg::S_LOAD_GO;
            end
         end
         sau_pkg::S_LOAD_GO: begin
            div_cmd.start    = 1'b1;
            div_cmd.dividend = start_ff;
            div_cmd.divisor  = g_ff;
            state_in         = sau_pkg::S_LOAD_WAIT;
         end
         sau_pkg::S_LOAD_WAIT: begin
            if (div_rsp.done) begin
               walk_in  = div_rsp.remainder;
               steps_in = '0;
               state_in = sau_pkg::S_IDLE;
            end
         end
         sau_pkg::S_IDLE: begin
            if (csr_fire) begin
               case (csr_index)
                  sau_pkg::CSR_TOTAL: begin
                     total_in = csr_wdata[CW-1:0];
                     state_in = sau_pkg::S_SETUP;
                  end
                  sau_pkg::CSR_FIXED: begin
                     fixed_in = csr_wdata[CW-1:0];
                     state_in = sau_pkg::S_SETUP;
                  end
                  sau_pkg::CSR_START: begin
                     start_in = csr_wdata;
                     state_in = sau_pkg::S_SETUP;
                  end
                  sau_pkg::CSR_STRIDE: begin
                     stride_in = csr_wdata;
                  end
                  default: begin
                  end
               endcase
            end else if (req_fire) begin
               op_in   = req_op;
               init_in = '0;
               r_in    = (req_op == sau_pkg::OP_UNRANK) ? req_rank_in : stride_ff;
               if (req_op == sau_pkg::OP_NEXT && steps_ff >= g_ff) begin
                  state_in = sau_pkg::S_EXH;
               end else begin
                  state_in = sau_pkg::S_MOD_GO;
               end
            end
         end
         sau_pkg::S_EXH: begin
            if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_position_in  = '0;
               rsp_element_in   = '0;
               rsp_rank_used_in = '0;
               rsp_last_in      = 1'b1;
               rsp_exhausted_in = 1'b1;
               state_in         = sau_pkg::S_IDLE;
            end
         end
         sau_pkg::S_MOD_GO, sau_pkg::S_MOD_WAIT: begin
            // fill the arrangement with the identity while the divider runs
            if (init_ff < n_eff) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = init_ff[EW-1:0];
               ram_wr_data = init_ff[EW-1:0];
               init_in     = init_ff + 1'b1;
            end
            if (state_ff == sau_pkg::S_MOD_GO) begin
               div_cmd.start    = 1'b1;
               div_cmd.dividend = r_ff;
               div_cmd.divisor  = g_ff;
               state_in         = sau_pkg::S_MOD_WAIT;
            end else if (div_rsp.done) begin
               if (op_ff == sau_pkg::OP_UNRANK) begin
                  used_in  = div_rsp.remainder;
                  r_in     = div_rsp.remainder;
                  state_in = sau_pkg::S_DSTART;
               end else begin
                  sum_in   = {1'b0, walk_ff} + {1'b0, div_rsp.remainder};
                  state_in = sau_pkg::S_STEP;
               end
            end
         end
         sau_pkg::S_STEP: begin
            walk_in  = step_rank;
            used_in  = step_rank;
            r_in     = step_rank;
            steps_in = steps_ff + 1'b1;
            state_in = sau_pkg::S_DSTART;
         end
         sau_pkg::S_DSTART: begin
            q_in = n_last;
            if (m_lt_n) begin
               p_in     = fixed_ff[EW-1:0];
               state_in = sau_pkg::S_DIG_GO;
            end else begin
               state_in = sau_pkg::S_SW_CHK;
            end
         end
         sau_pkg::S_DIG_GO: begin
            div_cmd.start    = 1'b1;
            div_cmd.narrow   = 1'b1;
            div_cmd.dividend = r_ff;
            div_cmd.divisor  = IB'(RW'(p_ff) + 1'b1);
            state_in         = sau_pkg::S_DIG_WAIT;
         end
         sau_pkg::S_DIG_WAIT: begin
            if (div_rsp.done) begin
               stk_ctl.push = 1'b1;
               stk_ctl.din  = div_rsp.remainder[EW-1:0];
               r_in         = div_rsp.quotient;
               if (p_ff == n_last) begin
                  state_in = sau_pkg::S_SW_CHK;
               end else begin
                  p_in     = p_ff + 1'b1;
                  state_in = sau_pkg::S_DIG_GO;
               end
            end
         end
         sau_pkg::S_SW_CHK: begin
            ram_rd_addr_a = q_ff;
            ram_rd_addr_b = q_ff - stk_top;
            if (stk_empty) begin
               em_in    = '0;
               state_in = sau_pkg::S_EM_RD;
            end else if (stk_top == '0) begin
               stk_ctl.pop = 1'b1;
               q_in        = q_ff - 1'b1;
            end else begin
               stk_ctl.pop = 1'b1;
               o_in        = q_ff - stk_top;
               state_in    = sau_pkg::S_SW_WQ;
            end
         end
         sau_pkg::S_SW_WQ: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = q_ff;
            ram_wr_data = ram_rd_data_b;
            tmp_in      = ram_rd_data_a;
            state_in    = sau_pkg::S_SW_WO;
         end
         sau_pkg::S_SW_WO: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = o_ff;
            ram_wr_data = tmp_ff;
            q_in        = q_ff - 1'b1;
            state_in    = sau_pkg::S_SW_CHK;
         end
         sau_pkg::S_EM_RD: begin
            ram_rd_addr_a = em_ff;
            state_in      = sau_pkg::S_EM_WR;
         end
         sau_pkg::S_EM_WR: begin
            ram_rd_addr_a = em_ff;
            if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_position_in  = em_ff;
               rsp_element_in   = ram_rd_data_a;
               rsp_rank_used_in = used_ff;
               rsp_last_in      = (em_ff == n_last);
               rsp_exhausted_in = 1'b0;
               if (em_ff == n_last) begin
                  state_in = sau_pkg::S_IDLE;
               end else begin
                  em_in    = em_ff + 1'b1;
                  state_in = sau_pkg::S_EM_RD;
               end
            end
         end
         default: begin
            state_in = sau_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sau_pkg::S_SETUP;
         total_ff     <= sau_pkg::RESET_TOTAL;
         fixed_ff     <= '0;
         start_ff     <= '0;
         stride_ff    <= sau_pkg::RESET_STRIDE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         fixed_ff     <= fixed_in;
         start_ff     <= start_in;
         stride_ff    <= stride_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      g_ff             <= g_in;
      walk_ff          <= walk_in;
      steps_ff         <= steps_in;
      used_ff          <= used_in;
      r_ff             <= r_in;
      sum_ff           <= sum_in;
      gp_ff            <= gp_in;
      init_ff          <= init_in;
      p_ff             <= p_in;
      q_ff             <= q_in;
      o_ff             <= o_in;
      em_ff            <= em_in;
      tmp_ff           <= tmp_in;
      op_ff            <= op_in;
      rsp_position_ff  <= rsp_position_in;
      rsp_element_ff   <= rsp_element_in;
      rsp_rank_used_ff <= rsp_rank_used_in;
      rsp_last_ff      <= rsp_last_in;
      rsp_exhausted_ff <= rsp_exhausted_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_position  = rsp_position_ff;
   assign rsp_element   = rsp_element_ff;
   assign rsp_rank_used = rsp_rank_used_ff;
   assign rsp_last      = rsp_last_ff;
   assign rsp_exhausted = rsp_exhausted_ff;

`ifndef SYNTHESIS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted while a word is still being worked");

   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_cmd.start |-> !div_rsp.busy)
      else $error("divider started while busy");

   a_exhausted_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_exhausted) |-> (rsp_last && rsp_rank_used == '0))
      else $error("exhausted word not a single final word");
`endif

endmodule

>>> sv/sau_ram.sv
// Generic single-write, dual-read RAM with registered read data.
// Stand-alone; no package dependency.
module sau_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a <= mem_ff[rd_addr_a];
      rd_data_b <= mem_ff[rd_addr_b];
   end

endmodule

>>> sv/sau_divider.sv
// Shared iterative divider: one quotient bit per cycle for wide divisors,
// eight bits per cycle for small radix divisors. Depends on sau_pkg.
module sau_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  sau_pkg::div_cmd_type cmd,
   output sau_pkg::div_rsp_type rsp
);

   localparam int IB = sau_pkg::INDEX_BITS;
   localparam int DW = sau_pkg::DIV_W;
   localparam int EW = sau_pkg::ELEM_W;
   localparam int RW = sau_pkg::RAD_W;
   localparam int NB = sau_pkg::NARROW_BITS;
   localparam int CNW = sau_pkg::DIV_CNT_W;

   logic           busy_ff;
   logic           done_ff;
   logic           narrow_ff;
   logic [CNW-1:0] cnt_ff;
   logic [DW-1:0]  quo_ff;
   logic [IB-1:0]  rem_ff;
   logic [IB-1:0]  dvs_ff;

   logic [IB:0]    wide_sh;
   logic [IB:0]    wide_diff;
   logic           wide_ge;
   logic [EW-1:0]  nar_r;
   logic [RW-1:0]  nar_t;
   logic [NB-1:0]  nar_q;

   assign wide_sh   = {rem_ff, quo_ff[DW-1]};
   assign wide_diff = wide_sh - {1'b0, dvs_ff};
   assign wide_ge   = wide_sh >= {1'b0, dvs_ff};

   always_comb begin
      nar_r = rem_ff[EW-1:0];
      nar_t = '0;
      nar_q = '0;
      for (int k = 0; k < NB; k++) begin
         nar_t = {nar_r, quo_ff[DW-1-k]};
         if (nar_t >= dvs_ff[RW-1:0]) begin
            nar_q[NB-1-k] = 1'b1;
            nar_r = EW'(nar_t - dvs_ff[RW-1:0]);
         end else begin
            nar_r = nar_t[EW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == CNW'(1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         narrow_ff <= cmd.narrow;
         quo_ff    <= DW'(cmd.dividend);
         rem_ff    <= '0;
         dvs_ff    <= cmd.divisor;
         cnt_ff    <= cmd.narrow ? CNW'(sau_pkg::NARROW_CYCLES) : CNW'(DW);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 1'b1;
         if (narrow_ff) begin
            quo_ff <= {quo_ff[DW-NB-1:0], nar_q};
            rem_ff <= IB'(nar_r);
         end else begin
            quo_ff <= {quo_ff[DW-2:0], wide_ge};
            rem_ff <= wide_ge ? wide_diff[IB-1:0] : wide_sh[IB-1:0];
         end
      end
   end

   assign rsp.busy      = busy_ff;
   assign rsp.done      = done_ff;
   assign rsp.quotient  = quo_ff[IB-1:0];
   assign rsp.remainder = rem_ff;

endmodule

>>> sv/sau_digits.sv
// Last-in first-out store of mixed-radix digits, top entry at a fixed tap.
// Depends on sau_pkg.
module sau_digits (
   input  logic                             clock,
   input  logic                             reset,
   input  sau_pkg::stack_ctl_type           ctl,
   output logic [sau_pkg::ELEM_W-1:0]       top,
   output logic                             empty
);

   localparam int DEPTH = sau_pkg::MAX_ELEMENTS;
   localparam int EW    = sau_pkg::ELEM_W;
   localparam int SCW   = sau_pkg::STACK_CNT_W;

   logic [EW-1:0]  st_ff [DEPTH];
   logic [SCW-1:0] count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (ctl.push) begin
         count_ff <= count_ff + 1'b1;
      end else if (ctl.pop) begin
         count_ff <= count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.push) begin
         st_ff[0] <= ctl.din;
         for (int i = 1; i < DEPTH; i++) begin
            st_ff[i] <= st_ff[i-1];
         end
      end else if (ctl.pop) begin
         for (int i = 0; i < DEPTH - 1; i++) begin
            st_ff[i] <= st_ff[i+1];
         end
      end
   end

   assign top   = st_ff[0];
   assign empty = (count_ff == '0);

endmodule
